// ===== src/event_timestamp_fifo_defines.svh =====
// assertion macros for the event timestamp fifo
`ifndef EVENT_TIMESTAMP_FIFO_DEFINES_SVH
`define EVENT_TIMESTAMP_FIFO_DEFINES_SVH

// same-cycle implication, checked on clk and masked during reset
`define ETF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("event_timestamp_fifo check failed");

// next-cycle implication, checked on clk and masked during reset
`define ETF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("event_timestamp_fifo check failed");

`endif

// ===== src/etf_pkg.sv =====
// shared constants and codes for the event timestamp fifo
package etf_pkg;

	localparam int DEPTH_DEF = 128;

	localparam int FUNC_W   = 2;
	localparam int STAMP_W  = 63;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 64;
	localparam int COUNT_W  = 8;

	localparam logic [FUNC_W-1:0] FUNC_CAPTURE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

// ===== src/event_timestamp_fifo.sv =====
// event timestamp ring buffer with lifetime event counter
//
// usage: a request (func, capture_time) transfers at a rising edge with start high
// and busy low. busy stays low, so a request may be issued every cycle.
// func capture stores capture_time and bumps the 64-bit lifetime total; on a full
// ring the event is dropped and status full is returned. func read pops the
// oldest timestamp and returns it with its event number; on an empty ring it
// returns status empty. func query, and the unused code, return the counters.
// every request gives exactly one result, registered in the cycle after its transfer: done is
// high for that single cycle with status, seq_number, event_timestamp,
// total_logged and buffered_count. throughput is one request per cycle, set by
// the single timestamp memory, which takes one write or one read per request;
// its read port is registered, so the timestamp arrives with the other result fields.
// the receiver cannot stall, so the result must be taken while done is high.
// reset clears the pointers, the fill level, the total and done; the memory
// keeps its contents, and an entry is only read after a capture wrote it.
`include "event_timestamp_fifo_defines.svh"

module event_timestamp_fifo #(
	parameter int DEPTH = etf_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [etf_pkg::FUNC_W-1:0]      func,
	input  logic [etf_pkg::STAMP_W-1:0]     capture_time,
	output logic                            done,
	output logic [etf_pkg::STATUS_W-1:0]    status,
	output logic [etf_pkg::TOTAL_W-1:0]     seq_number,
	output logic [etf_pkg::STAMP_W-1:0]     event_timestamp,
	output logic [etf_pkg::TOTAL_W-1:0]     total_logged,
	output logic [etf_pkg::COUNT_W-1:0]     buffered_count
);
	import etf_pkg::*;

	localparam int PTR_W  = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);

	localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);

	logic [STAMP_W-1:0] stamp_mem [DEPTH];
	logic [STAMP_W-1:0] rd_data_q;

	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [FILL_W-1:0]  fill_q;
	logic [TOTAL_W-1:0] total_q;

	logic                done_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [TOTAL_W-1:0]  number_s1;
	logic                pop_s1;
	logic [TOTAL_W-1:0]  total_s1;
	logic [COUNT_W-1:0]  count_s1;

	logic                accept;
	logic                full;
	logic                empty;
	logic                push;
	logic                pop;
	logic [PTR_W-1:0]    wr_ptr_nxt;
	logic [PTR_W-1:0]    rd_ptr_nxt;
	logic [FILL_W-1:0]   fill_nxt;
	logic [TOTAL_W-1:0]  total_nxt;
	logic [STATUS_W-1:0] status_nxt;
	logic [TOTAL_W-1:0]  number_nxt;
	logic [FILL_W+COUNT_W-1:0] fill_ext;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (fill_q == FILL_FULL);
	assign empty  = (fill_q == '0);

	always_comb begin
		push       = 1'b0;
		pop        = 1'b0;
		status_nxt = STATUS_OK;
		unique case (func)
			FUNC_CAPTURE: begin
				if (full) begin
					status_nxt = STATUS_FULL;
				end else begin
					push = accept;
				end
			end
			FUNC_READ: begin
				if (empty) begin
					status_nxt = STATUS_EMPTY;
				end else begin
					pop = accept;
				end
			end
			default: begin
				status_nxt = STATUS_OK;
			end
		endcase
	end

	assign wr_ptr_nxt = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_ptr_nxt = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
	assign fill_nxt   = push ? fill_q + 1'b1 : (pop ? fill_q - 1'b1 : fill_q);
	assign total_nxt  = push ? total_q + 1'b1 : total_q;
	assign number_nxt = pop ? total_q - TOTAL_W'(fill_q) + 1'b1 : '0;
	assign fill_ext   = {{COUNT_W{1'b0}}, fill_nxt};

	// timestamp memory, one write or one read per request
	always_ff @(posedge clk) begin
		if (push) begin
			stamp_mem[wr_ptr_q] <= capture_time;
		end
		if (pop) begin
			rd_data_q <= stamp_mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			total_q  <= '0;
			done_s1  <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (push) begin
				wr_ptr_q <= wr_ptr_nxt;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_nxt;
			end
			if (accept) begin
				fill_q  <= fill_nxt;
				total_q <= total_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_nxt;
			number_s1 <= number_nxt;
			pop_s1    <= pop;
			total_s1  <= total_nxt;
			count_s1  <= fill_ext[COUNT_W-1:0];
		end
	end

	assign done            = done_s1;
	assign status          = status_s1;
	assign seq_number      = number_s1;
	assign event_timestamp = pop_s1 ? rd_data_q : '0;
	assign total_logged    = total_s1;
	assign buffered_count  = count_s1;

	`ETF_ASSERT_NEXT(a_result_follows_transfer, accept, done)
	`ETF_ASSERT_NEXT(a_no_stray_result, !accept, !done)
	`ETF_ASSERT_NOW(a_fill_in_range, 1'b1, fill_q <= FILL_FULL)
	`ETF_ASSERT_NEXT(a_capture_counts, push, total_q == $past(total_q) + 1'b1)
	`ETF_ASSERT_NOW(a_full_only_when_full, done && (status == STATUS_FULL), full)

endmodule

// ===== dv/tb_top.sv =====
// self-checking bench for event_timestamp_fifo: directed and random requests vs a ring model
module tb_top;
	import etf_pkg::*;

	localparam int RING_DEPTH = DEPTH_DEF;
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
	localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TOTAL_W-1:0]  seq_number;
		logic [STAMP_W-1:0]  event_timestamp;
		logic [TOTAL_W-1:0]  total_logged;
		logic [COUNT_W-1:0]  buffered_count;
	} answer_t;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	class stamp_ring_tracker;
		logic [STAMP_W-1:0] ring [RING_DEPTH];
		int unsigned        wr_idx;
		int unsigned        rd_idx;
		int unsigned        held;
		logic [TOTAL_W-1:0] events_total;
		answer_t            due_answers [$];
		int                 errors;

		function new();
			wr_idx = 0;
			rd_idx = 0;
			held = 0;
			events_total = '0;
			errors = 0;
		endfunction

		// apply one accepted request to the ring and queue its answer
		function void log_request(logic [FUNC_W-1:0] f, logic [STAMP_W-1:0] t);
			answer_t a;
			a = '0;
			a.status = STATUS_OK;
			if (f == FUNC_CAPTURE) begin
				if (held >= RING_DEPTH) begin
					a.status = STATUS_FULL;
				end else begin
					ring[wr_idx] = t;
					wr_idx = (wr_idx + 1) % RING_DEPTH;
					held++;
					events_total++;
				end
			end else if (f == FUNC_READ) begin
				if (held == 0) begin
					a.status = STATUS_EMPTY;
				end else begin
					a.event_timestamp = ring[rd_idx];
					a.seq_number = events_total - TOTAL_W'(held) + 64'd1;
					rd_idx = (rd_idx + 1) % RING_DEPTH;
					held--;
				end
			end
			a.total_logged = events_total;
			a.buffered_count = COUNT_W'(held);
			due_answers.push_back(a);
		endfunction

		function void compare_field(string name, logic [63:0] exp, logic [63:0] act);
			if (exp !== act) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
				errors++;
			end
		endfunction

		function void match_answer(answer_t got);
			answer_t exp;
			if (due_answers.size() == 0) begin
				$display("%0t: result with no request pending, expected none, actual %p",
					$time, got);
				errors++;
			end else begin
				exp = due_answers.pop_front();
				compare_field("status", 64'(exp.status), 64'(got.status));
				compare_field("seq_number", exp.seq_number, got.seq_number);
				compare_field("event_timestamp", 64'(exp.event_timestamp),
					64'(got.event_timestamp));
				compare_field("total_logged", exp.total_logged, got.total_logged);
				compare_field("buffered_count", 64'(exp.buffered_count),
					64'(got.buffered_count));
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [FUNC_W-1:0]   func = FUNC_QUERY;
	logic [STAMP_W-1:0]  capture_time = '0;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [TOTAL_W-1:0]  seq_number;
	logic [STAMP_W-1:0]  event_timestamp;
	logic [TOTAL_W-1:0]  total_logged;
	logic [COUNT_W-1:0]  buffered_count;

	stamp_ring_tracker tracker = new();
	int                sent = 0;
	bit                idle_ok = 1'b1;

	event_timestamp_fifo u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.capture_time    (capture_time),
		.done            (done),
		.status          (status),
		.seq_number      (seq_number),
		.event_timestamp (event_timestamp),
		.total_logged    (total_logged),
		.buffered_count  (buffered_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// requests are logged before results are matched so a same-edge pair stays ordered
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				tracker.log_request(func, capture_time);
			if (done)
				tracker.match_answer({status, seq_number, event_timestamp,
					total_logged, buffered_count});
		end
	end

	task automatic issue(logic [FUNC_W-1:0] f, logic [STAMP_W-1:0] t);
		if (idle_ok && $urandom_range(0, 99) < 7) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		capture_time <= t;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	function automatic logic [STAMP_W-1:0] pick_stamp();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		else if (sel == 1)
			return STAMP_MAX;
		return STAMP_W'({$urandom, $urandom});
	endfunction

	function automatic logic [FUNC_W-1:0] pick_func(mix_t m);
		int r;
		r = $urandom_range(0, 99);
		case (m)
			MIX_FILL: begin
				if (r < 80) return FUNC_CAPTURE;
				if (r < 90) return FUNC_READ;
				if (r < 95) return FUNC_QUERY;
				return FUNC_SPARE;
			end
			MIX_DRAIN: begin
				if (r < 80) return FUNC_READ;
				if (r < 92) return FUNC_CAPTURE;
				if (r < 96) return FUNC_QUERY;
				return FUNC_SPARE;
			end
			default: begin
				if (r < 45) return FUNC_CAPTURE;
				if (r < 90) return FUNC_READ;
				if (r < 95) return FUNC_QUERY;
				return FUNC_SPARE;
			end
		endcase
	endfunction

	initial begin
		mix_t mode;
		int   run_len;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty ring, extremes of the stamp, unused code, drain back to empty
		issue(FUNC_QUERY, STAMP_MAX);
		issue(FUNC_READ, STAMP_MAX);
		issue(FUNC_SPARE, STAMP_MAX);
		issue(FUNC_CAPTURE, '0);
		issue(FUNC_CAPTURE, STAMP_MAX);
		issue(FUNC_CAPTURE, {32'h5555_5555, 31'h5555_5555});
		issue(FUNC_CAPTURE, {32'haaaa_aaaa, 31'h2aaa_aaaa});
		issue(FUNC_QUERY, '0);
		issue(FUNC_SPARE, '0);
		issue(FUNC_READ, '0);
		issue(FUNC_READ, STAMP_MAX);
		issue(FUNC_READ, '0);
		issue(FUNC_READ, '0);
		issue(FUNC_READ, '0);
		issue(FUNC_CAPTURE, {1'b1, 62'd1});
		issue(FUNC_QUERY, STAMP_MAX);
		issue(FUNC_READ, '0);
		issue(FUNC_QUERY, '0);

		// random phases; the first one fills past capacity so the full case is hit early
		mode = MIX_FILL;
		run_len = 2 * RING_DEPTH;
		while (sent < 650) begin
			for (int i = 0; i < run_len && sent < 650; i++) begin
				idle_ok = !(sent >= 300 && sent < 450);
				issue(pick_func(mode), pick_stamp());
			end
			mode = mix_t'($urandom_range(0, 2));
			run_len = $urandom_range(20, 180);
		end

		idle_ok = 1'b1;
		start <= 1'b0;
		while (tracker.due_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (tracker.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#500000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
